/* src/rpt_pkg.sv */
// Package: shared types and constants for the relay permission table.
`default_nettype none
package rpt_pkg;
    localparam int TABLE_ENTRIES = 64;
    localparam int SLOT_W = $clog2(TABLE_ENTRIES);
    localparam logic [15:0] DEFAULT_LIFETIME = 16'd300;
    localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        REQ_LOOKUP = 2'd0,
        REQ_CREATE = 2'd1,
        REQ_TX     = 2'd2,
        REQ_RX     = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_FAMILY   = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    localparam logic [0:0] CFG_LIFETIME = 1'd0;
    localparam logic [0:0] CFG_FAMILY   = 1'd1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] peer_addr_high;
        logic [63:0] peer_addr_low;
        logic        peer_is_v6;
        logic [15:0] byte_count;
        logic [31:0] now_seconds;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  entry_slot;
        logic [15:0] remaining_seconds;
        logic [31:0] tx_packets;
        logic [31:0] rx_packets;
    } t_out_item;

    // Request broadcast through the row of cells.
    typedef struct packed {
        logic        active;
        logic        do_create;
        logic [1:0]  req_type;
        logic [63:0] hi;
        logic [63:0] lo;
        logic        v6;
        logic [15:0] bytes;
        logic [31:0] now;
        logic [31:0] expiry;
    } t_cmd;

    // Token passed cell to cell: first live match and first free slot so far.
    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] found_idx;
        logic              free;
        logic [SLOT_W-1:0] free_idx;
    } t_chain;

    typedef struct packed {
        logic [31:0] expiry;
        logic [31:0] tx_packets;
        logic [31:0] rx_packets;
    } t_cell_data;
endpackage
`default_nettype wire

/* src/rpt_stream_if.sv */
// Interfaces: valid/ready channels for request and result items.
`default_nettype none
interface rpt_in_if;
    logic                   valid;
    logic                   ready;
    rpt_pkg::t_in_item      data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rpt_out_if;
    logic                   valid;
    logic                   ready;
    rpt_pkg::t_out_item     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

/* src/rpt_cell.sv */
// One table slot: key, expiry and counters, with match and free detection.
`default_nettype none
module rpt_cell (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [rpt_pkg::SLOT_W-1:0]  i_idx,
    input  wire rpt_pkg::t_cmd               i_cmd,
    input  wire logic                        i_commit,
    input  wire logic                        i_win_create,
    input  wire logic                        i_win_count,
    input  wire rpt_pkg::t_chain             i_chain,
    output rpt_pkg::t_chain                  o_chain,
    output rpt_pkg::t_cell_data              o_data
);
    import rpt_pkg::*;

    logic        r_valid;
    logic [63:0] r_hi, r_lo;
    logic        r_v6;
    logic [31:0] r_exp, r_txp, r_rxp;
    logic [47:0] r_txb, r_rxb;

    logic key_eq, live, match_live, match_dead;
    logic [48:0] txb_sum, rxb_sum;

    assign key_eq     = r_valid && r_v6 == i_cmd.v6 && r_hi == i_cmd.hi && r_lo == i_cmd.lo;
    assign live       = r_valid && i_cmd.now <= r_exp;
    assign match_live = key_eq && live;
    assign match_dead = key_eq && !live;
    assign txb_sum    = {1'b0, r_txb} + {33'd0, i_cmd.bytes};
    assign rxb_sum    = {1'b0, r_rxb} + {33'd0, i_cmd.bytes};

    always_comb begin
        o_chain = i_chain;
        if (!i_chain.found && match_live) begin
            o_chain.found     = 1'b1;
            o_chain.found_idx = i_idx;
        end
        if (!i_chain.free && !live) begin
            o_chain.free     = 1'b1;
            o_chain.free_idx = i_idx;
        end
    end

    // only the matched slot drives its values, the top ORs all cells together
    always_comb begin
        o_data = '0;
        if (i_win_count) o_data = '{expiry: r_exp, tx_packets: r_txp, rx_packets: r_rxp};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_commit) begin
            // expired matches are dropped on any search that is still active
            if (i_cmd.active && match_dead) r_valid <= 1'b0;
            if (i_win_create) r_valid <= 1'b1;
        end
        if (i_commit) begin
            if (i_win_create) begin
                r_hi  <= i_cmd.hi;
                r_lo  <= i_cmd.lo;
                r_v6  <= i_cmd.v6;
                r_exp <= i_cmd.expiry;
                r_txp <= '0;
                r_rxp <= '0;
                r_txb <= '0;
                r_rxb <= '0;
            end else if (i_win_count) begin
                if (i_cmd.req_type == REQ_CREATE) begin
                    r_exp <= i_cmd.expiry;
                end else if (i_cmd.req_type == REQ_TX) begin
                    if (r_txp != '1) r_txp <= r_txp + 32'd1;
                    r_txb <= txb_sum[48] ? MAX48 : txb_sum[47:0];
                end else if (i_cmd.req_type == REQ_RX) begin
                    if (r_rxp != '1) r_rxp <= r_rxp + 32'd1;
                    r_rxb <= rxb_sum[48] ? MAX48 : rxb_sum[47:0];
                end
            end
        end
    end
endmodule
`default_nettype wire

/* src/relay_permission_table_unit.sv */
// Top level: request channel, row of slot cells, result register.
// Usage:
//   i_req carries one request item (lookup, create/refresh, tx or rx count);
//   o_rsp returns exactly one result item per request, in order.
//   Config writes (i_cfg_we/i_cfg_idx/i_cfg_data) go in while idle:
//   index 0 is the lifetime in seconds, index 1 the relay family.
// Steps: the request is latched, the match and free tokens ripple through the row
//   of slot cells and are registered, then the chosen slot updates and the result is
//   registered. One item is in work at a time; a request is accepted only in the cycle
//   after the previous result has left the output register.
// Reset clears all slot valid bits, the lifetime to 300 s and family to IPv4.
// When the sink stalls, the result holds in the output register and no new
//   request is taken until it is accepted.
`default_nettype none
module relay_permission_table_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    rpt_in_if.sink           i_req,
    rpt_out_if.source        o_rsp,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data
);
    import rpt_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_COMMIT, S_OUT} t_state;

    t_state r_state;
    logic [15:0] r_lifetime;
    logic        r_family;
    t_cmd        r_cmd;
    t_chain      r_res;
    t_out_item   r_out;

    t_chain     chain [TABLE_ENTRIES+1];
    t_cell_data cdata [TABLE_ENTRIES];
    t_cell_data hit_data;
    logic       commit;
    logic [32:0] exp_sum;
    logic       mismatch;
    t_in_item   in;
    logic [SLOT_W-1:0] win_idx;
    logic       win_create_any, win_count_any;

    assign in = i_req.data;
    assign exp_sum = {1'b0, in.now_seconds} + {17'd0, r_lifetime};
    assign commit = r_state == S_COMMIT;
    assign chain[0] = '0;
    assign mismatch = r_cmd.do_create && (r_cmd.v6 != r_family);
    assign win_count_any  = r_cmd.active && r_res.found;
    assign win_create_any = r_cmd.active && r_cmd.do_create && !r_res.found && r_res.free;
    assign win_idx = r_res.found ? r_res.found_idx : r_res.free_idx;

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_cell
        rpt_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_idx       (SLOT_W'(g)),
            .i_cmd       (r_cmd),
            .i_commit    (commit),
            .i_win_create(win_create_any && r_res.free_idx == SLOT_W'(g)),
            .i_win_count (win_count_any && r_res.found_idx == SLOT_W'(g)),
            .i_chain     (chain[g]),
            .o_chain     (chain[g+1]),
            .o_data      (cdata[g])
        );
    end

    // at most one cell drives nonzero data
    always_comb begin
        hit_data = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) hit_data = hit_data | cdata[i];
    end

    assign i_req.ready = r_state == S_IDLE;
    assign o_rsp.valid = r_state == S_OUT;
    assign o_rsp.data  = r_out;

    // result values after the slot update
    t_out_item nxt_out;
    logic [31:0] rem, v_exp, v_tx, v_rx;
    always_comb begin
        v_exp = hit_data.expiry;
        v_tx  = hit_data.tx_packets;
        v_rx  = hit_data.rx_packets;
        if (win_create_any) begin
            v_exp = r_cmd.expiry; v_tx = '0; v_rx = '0;
        end else if (r_cmd.req_type == REQ_CREATE) begin
            v_exp = r_cmd.expiry;
        end else if (r_cmd.req_type == REQ_TX) begin
            if (v_tx != '1) v_tx = v_tx + 32'd1;
        end else if (r_cmd.req_type == REQ_RX) begin
            if (v_rx != '1) v_rx = v_rx + 32'd1;
        end
        rem = v_exp - r_cmd.now;
        nxt_out = '0;
        if (!r_cmd.active) begin
            nxt_out.status = ST_FAMILY;
        end else if (r_res.found || win_create_any) begin
            nxt_out.status = ST_OK;
            nxt_out.entry_slot = 6'(win_idx);
            nxt_out.remaining_seconds = (rem > 32'hFFFF) ? 16'hFFFF : rem[15:0];
            nxt_out.tx_packets = v_tx;
            nxt_out.rx_packets = v_rx;
        end else begin
            nxt_out.status = r_cmd.do_create ? ST_FULL : ST_NOTFOUND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_lifetime <= DEFAULT_LIFETIME;
            r_family   <= 1'b0;
            r_cmd.active <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_LIFETIME) r_lifetime <= i_cfg_data;
                else r_family <= i_cfg_data[0];
            end
            case (r_state)
                S_IDLE: if (i_req.valid) begin
                    r_cmd.active    <= 1'b1;
                    r_cmd.do_create <= in.req_type == REQ_CREATE;
                    r_cmd.req_type  <= in.req_type;
                    r_cmd.v6        <= in.peer_is_v6;
                    r_cmd.hi        <= in.peer_is_v6 ? in.peer_addr_high : 64'd0;
                    r_cmd.lo        <= in.peer_is_v6 ? in.peer_addr_low
                                                     : {32'd0, in.peer_addr_low[31:0]};
                    r_cmd.bytes     <= in.byte_count;
                    r_cmd.now       <= in.now_seconds;
                    r_cmd.expiry    <= exp_sum[32] ? 32'hFFFF_FFFF : exp_sum[31:0];
                    r_state <= S_SEARCH;
                end
                S_SEARCH: begin
                    if (mismatch) r_cmd.active <= 1'b0;
                    r_state <= S_COMMIT;
                end
                S_COMMIT: r_state <= S_OUT;
                S_OUT: if (o_rsp.ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SEARCH) r_res <= chain[TABLE_ENTRIES];
        if (commit) r_out <= nxt_out;
    end

    a_ok_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && o_rsp.data.status != ST_OK |-> o_rsp.data.entry_slot == '0)
        else $error("nonzero slot on failure");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid)
        else $error("result dropped");
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> ##1 o_rsp.valid == 1'b0)
        else $error("early result");
endmodule
`default_nettype wire

/* bench/relay_permission_table_checker.sv */
// Checker: watches request, result and config ports, predicts and compares results.
`timescale 1ns / 1ps
module relay_permission_table_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    rpt_in_if                i_req,
    rpt_out_if               i_rsp,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [15:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);
    import rpt_pkg::*;

    logic [15:0] lifetime;
    logic        family_v6;
    logic        perm_valid [TABLE_ENTRIES];
    logic [63:0] perm_hi    [TABLE_ENTRIES];
    logic [63:0] perm_lo    [TABLE_ENTRIES];
    logic        perm_v6    [TABLE_ENTRIES];
    logic [31:0] perm_exp   [TABLE_ENTRIES];
    logic [31:0] perm_txp   [TABLE_ENTRIES];
    logic [31:0] perm_rxp   [TABLE_ENTRIES];
    t_out_item   expected_rsp_q[$];

    function automatic logic [31:0] expiry_at(logic [31:0] now);
        logic [32:0] sum;
        sum = {1'b0, now} + {17'd0, lifetime};
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    // lowest live match; every expired match is dropped on the way
    function automatic int find_perm(logic [63:0] hi, logic [63:0] lo, logic v6,
                                     logic [31:0] now);
        int hit;
        hit = -1;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (perm_valid[i] && perm_v6[i] == v6 && perm_hi[i] == hi && perm_lo[i] == lo)
            begin
                if (now > perm_exp[i]) perm_valid[i] = 1'b0;
                else if (hit < 0) hit = i;
            end
        end
        return hit;
    endfunction

    function automatic t_out_item apply_request(t_in_item it);
        t_out_item   r;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [31:0] rem;
        int          s;
        int          i;
        r  = '0;
        hi = it.peer_is_v6 ? it.peer_addr_high : 64'd0;
        lo = it.peer_is_v6 ? it.peer_addr_low : {32'd0, it.peer_addr_low[31:0]};
        if (t_req'(it.req_type) == REQ_CREATE) begin
            if (it.peer_is_v6 != family_v6) begin
                r.status = ST_FAMILY;
                return r;
            end
            s = find_perm(hi, lo, it.peer_is_v6, it.now_seconds);
            if (s >= 0) begin
                perm_exp[s] = expiry_at(it.now_seconds);
            end else begin
                for (i = 0; i < TABLE_ENTRIES; i++)
                    if (!perm_valid[i] || it.now_seconds > perm_exp[i]) break;
                if (i == TABLE_ENTRIES) begin
                    r.status = ST_FULL;
                    return r;
                end
                s = i;
                perm_valid[s] = 1'b1;
                perm_hi[s]    = hi;
                perm_lo[s]    = lo;
                perm_v6[s]    = it.peer_is_v6;
                perm_exp[s]   = expiry_at(it.now_seconds);
                perm_txp[s]   = '0;
                perm_rxp[s]   = '0;
            end
        end else begin
            s = find_perm(hi, lo, it.peer_is_v6, it.now_seconds);
            if (s < 0) begin
                r.status = ST_NOTFOUND;
                return r;
            end
            if (t_req'(it.req_type) == REQ_TX && perm_txp[s] != 32'hFFFF_FFFF)
                perm_txp[s]++;
            if (t_req'(it.req_type) == REQ_RX && perm_rxp[s] != 32'hFFFF_FFFF)
                perm_rxp[s]++;
        end
        rem = perm_exp[s] - it.now_seconds;
        r.status            = ST_OK;
        r.entry_slot        = s[5:0];
        r.remaining_seconds = (rem > 32'hFFFF) ? 16'hFFFF : rem[15:0];
        r.tx_packets        = perm_txp[s];
        r.rx_packets        = perm_rxp[s];
        return r;
    endfunction

    task automatic compare_rsp(t_out_item got);
        t_out_item want;
        if (expected_rsp_q.size() == 0) begin
            $error("unexpected result item %h", got);
            o_fail_count++;
            return;
        end
        want = expected_rsp_q.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, got.status);
            o_fail_count++;
        end
        if (got.entry_slot !== want.entry_slot) begin
            $error("entry_slot: expected %0d actual %0d", want.entry_slot, got.entry_slot);
            o_fail_count++;
        end
        if (got.remaining_seconds !== want.remaining_seconds) begin
            $error("remaining_seconds: expected %0d actual %0d",
                   want.remaining_seconds, got.remaining_seconds);
            o_fail_count++;
        end
        if (got.tx_packets !== want.tx_packets) begin
            $error("tx_packets: expected %0d actual %0d", want.tx_packets, got.tx_packets);
            o_fail_count++;
        end
        if (got.rx_packets !== want.rx_packets) begin
            $error("rx_packets: expected %0d actual %0d", want.rx_packets, got.rx_packets);
            o_fail_count++;
        end
    endtask

    initial o_fail_count = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lifetime  = DEFAULT_LIFETIME;
            family_v6 = 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++) perm_valid[i] = 1'b0;
            expected_rsp_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_LIFETIME) lifetime = i_cfg_data;
                else family_v6 = i_cfg_data[0];
            end
            if (i_rsp.valid && i_rsp.ready) compare_rsp(i_rsp.data);
            if (i_req.valid && i_req.ready) expected_rsp_q.push_back(apply_request(i_req.data));
        end
        o_pending <= expected_rsp_q.size();
    end
endmodule

/* bench/relay_permission_table_unit_tb.sv */
// Testbench top: clock, reset, stimulus, config phases and verdict.
`timescale 1ns / 1ps
module relay_permission_table_unit_tb;
    import rpt_pkg::*;

    localparam int POOL_N = 80;
    localparam int IDLE_LIMIT = 5000;

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic        cfg_idx;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    bit          long_stall_req;
    bit          no_idle;
    logic [31:0] now_t;
    logic        cur_family;
    logic [63:0] pool_hi [POOL_N];
    logic [63:0] pool_lo [POOL_N];

    rpt_in_if  req_if();
    rpt_out_if rsp_if();

    relay_permission_table_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_if),
        .o_rsp      (rsp_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    relay_permission_table_checker checker_u (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        if (no_idle) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic t_in_item make_item(t_req req, int idx, logic v6, logic [15:0] bytes);
        t_in_item it;
        it.req_type       = req;
        it.peer_is_v6     = v6;
        // v4 keys carry junk in the ignored bits
        it.peer_addr_high = v6 ? pool_hi[idx] : rand64();
        it.peer_addr_low  = v6 ? pool_lo[idx] : {$urandom(), pool_lo[idx][31:0]};
        it.byte_count     = bytes;
        it.now_seconds    = now_t;
        return it;
    endfunction

    task automatic send_item(t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= it;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_config(logic [15:0] life, logic fam);
        wait_drained();
        cur_family   = fam;
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_LIFETIME;
        cfg_data <= life;
        @(posedge i_clk);
        cfg_idx  <= CFG_FAMILY;
        cfg_data <= {15'd0, fam};
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic step_time();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) now_t = now_t + $urandom_range(0, 2);
        else if (r < 90) now_t = now_t + $urandom_range(3, 400);
        else if (r < 95) now_t = now_t - $urandom_range(0, 5);
        else now_t = now_t + $urandom_range(1000, 70000);
    endtask

    task automatic random_items(int count, int pool_used);
        t_req req;
        logic v6;
        int   r;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            req = (r < 35) ? REQ_CREATE : (r < 55) ? REQ_LOOKUP : (r < 78) ? REQ_TX : REQ_RX;
            v6 = ($urandom_range(0, 99) < 85) ? cur_family : ~cur_family;
            step_time();
            send_item(make_item(req, $urandom_range(0, pool_used - 1), v6, 16'($urandom())));
        end
    endtask

    // sink side: random ready, with a long hold-off on request
    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            if (long_stall_req) begin
                rsp_if.ready <= 1'b0;
                repeat (200) @(posedge i_clk);
                long_stall_req = 1'b0;
            end else if (no_idle) begin
                rsp_if.ready <= 1'b1;
                @(posedge i_clk);
            end else begin
                case ($urandom_range(0, 19))
                    0: begin
                        rsp_if.ready <= 1'b0;
                        repeat ($urandom_range(20, 60)) @(posedge i_clk);
                    end
                    1, 2, 3, 4, 5: begin
                        rsp_if.ready <= 1'b0;
                        repeat ($urandom_range(1, 3)) @(posedge i_clk);
                    end
                    default: begin
                        rsp_if.ready <= 1'b1;
                        repeat ($urandom_range(1, 8)) @(posedge i_clk);
                    end
                endcase
            end
        end
    end

    // watchdog on cycles with no item moving on either channel
    initial begin
        idle_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("relay_permission_table_unit regression: fail");
                $finish;
            end
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= CFG_LIFETIME;
        cfg_data     <= '0;
        req_if.valid <= 1'b0;
        req_if.data  <= '0;
        long_stall_req = 1'b0;
        no_idle        = 1'b0;
        cur_family     = 1'b0;
        for (int i = 0; i < POOL_N; i++) begin
            pool_hi[i] = rand64();
            pool_lo[i] = rand64();
        end
        // same low bits in both families, and all-ones / all-zero keys
        pool_hi[0] = '0;
        pool_lo[0] = 64'h0000_0000_C0A8_0001;
        pool_hi[1] = '1;
        pool_lo[1] = '1;
        pool_hi[2] = '0;
        pool_lo[2] = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed, reset config: lifetime 300, IPv4 relay
        now_t = 32'd100;
        send_item(make_item(REQ_LOOKUP, 0, 1'b0, 16'd0));
        send_item(make_item(REQ_CREATE, 0, 1'b0, 16'd0));
        send_item(make_item(REQ_LOOKUP, 0, 1'b0, 16'd0));
        send_item(make_item(REQ_TX, 0, 1'b0, 16'hFFFF));
        send_item(make_item(REQ_RX, 0, 1'b0, 16'd1));
        send_item(make_item(REQ_TX, 0, 1'b0, 16'd0));
        send_item(make_item(REQ_CREATE, 0, 1'b1, 16'd0));    // family mismatch
        send_item(make_item(REQ_LOOKUP, 0, 1'b1, 16'd0));
        send_item(make_item(REQ_CREATE, 1, 1'b0, 16'd0));
        send_item(make_item(REQ_CREATE, 2, 1'b0, 16'd0));
        now_t = 32'd110;
        send_item(make_item(REQ_CREATE, 0, 1'b0, 16'd0));    // refresh keeps counters
        send_item(make_item(REQ_RX, 1, 1'b0, 16'd7));
        now_t = 32'd400;                                     // slot 1 expiry exactly
        send_item(make_item(REQ_LOOKUP, 1, 1'b0, 16'd0));
        now_t = 32'd401;
        send_item(make_item(REQ_TX, 1, 1'b0, 16'd9));        // expired, removed
        send_item(make_item(REQ_CREATE, 3, 1'b0, 16'd0));    // reuses expired slot
        now_t = 32'd50;                                      // time going backwards
        send_item(make_item(REQ_LOOKUP, 0, 1'b0, 16'd0));
        send_item(make_item(REQ_LOOKUP, 3, 1'b0, 16'd0));

        write_config(16'd1, 1'b0);
        long_stall_req = 1'b1;
        random_items(100, 6);

        write_config(16'd0, 1'b0);                           // zero lifetime
        random_items(80, 4);

        // fill the table with long-lived IPv6 entries until it reports full
        write_config(16'hFFFF, 1'b1);
        for (int i = 0; i < POOL_N; i++) begin
            now_t = now_t + $urandom_range(0, 1);
            send_item(make_item(REQ_CREATE, i, 1'b1, 16'($urandom())));
        end
        wait_drained();
        no_idle = 1'b1;
        random_items(60, POOL_N);
        no_idle = 1'b0;

        write_config(DEFAULT_LIFETIME, 1'b1);
        random_items(100, 8);

        // expiry saturates near the top of the time range
        write_config(16'hFFFF, 1'b0);
        now_t = 32'hFFFF_0000 + $urandom_range(0, 16'hFFFF);
        random_items(100, 8);

        write_config(16'($urandom_range(1, 16'hFFFE)), 1'($urandom_range(0, 1)));
        now_t = $urandom();
        random_items(210, 10);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (fail_count == 0)
            $display("relay_permission_table_unit regression: pass");
        else
            $display("relay_permission_table_unit regression: fail");
        $finish;
    end
endmodule
